/* rtl/gdh_pkg.sv */
// Package for the graph degree histogram: request and result structs and code constants.
// No dependencies; imported by graph_degree_histogram.
`timescale 1ns / 1ps

package gdh_pkg;

    localparam int NODE_W  = 12;  // node index field width
    localparam int QDEG_W  = 11;  // query degree field width
    localparam int KIND_W  = 2;   // histogram kind field width
    localparam int CNT_W   = 13;  // histogram entry / node count width

    // Commands
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Histogram kinds
    localparam logic [KIND_W-1:0] KIND_IN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OUT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOT = 2'd2;

    typedef struct packed {
        logic              command;
        logic [NODE_W-1:0] src_node;
        logic [NODE_W-1:0] dst_node;
        logic [KIND_W-1:0] query_kind;
        logic [QDEG_W-1:0] query_degree;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0] node_count;
        logic             saturated;
    } t_res;

endpackage

/* rtl/graph_degree_histogram.sv */
// Graph degree histogram: per-node degree stores, three degree histograms,
// and a sequencer around one shared +/-1 unit. Depends on gdh_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel (i_in_valid / o_in_stall / i_in): add a directed edge or
//   query one histogram entry. Result channel (o_out_valid / i_out_stall /
//   o_out): one result per query, none per edge.
//   After reset the block runs a clearing pass over the degree and histogram
//   memories, one entry of each per cycle; o_in_stall stays high.
//   A query passes S_Q_WAIT, where its bucket is read, and S_Q_DATA, where
//   its result is loaded into the output register. An edge runs four degree
//   updates through the shared +/-1 unit. S_DEG_RD and S_DEG_CHK read a
//   degree; a saturated one is left as it is, else it is written back raised,
//   S_DEC_RD and S_DEC_WR take the node out of its old bucket if the degree
//   was above zero, and S_INC_RD and S_INC_WR put it into the new one. An
//   edge naming a node at or above NODES is dropped in its accept cycle.
//   The block takes one request at a time. When the receiver stalls, the
//   finished result holds in the output register; a following edge proceeds,
//   and a following query waits for the register to free up.

module graph_degree_histogram
    import gdh_pkg::*;
#(
    parameter int NODES      = 4096,
    parameter int MAX_DEGREE = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out
);

    localparam int AW         = (NODES > 2) ? $clog2(NODES) : 1;
    localparam int HAW        = (MAX_DEGREE > 2) ? $clog2(MAX_DEGREE) : 1;
    localparam int DW         = $clog2(MAX_DEGREE + 1);
    localparam int CW         = (AW > HAW) ? AW : HAW;
    localparam int UW         = (DW > CNT_W) ? DW : CNT_W;
    localparam int DEG_DEPTH  = 3 * (2 ** AW);
    localparam int HIST_DEPTH = 3 * (2 ** HAW);

    // Sequencer states
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DEG_RD  = 4'd2;
    localparam logic [3:0] S_DEG_CHK = 4'd3;
    localparam logic [3:0] S_DEC_RD  = 4'd4;
    localparam logic [3:0] S_DEC_WR  = 4'd5;
    localparam logic [3:0] S_INC_RD  = 4'd6;
    localparam logic [3:0] S_INC_WR  = 4'd7;
    localparam logic [3:0] S_Q_WAIT  = 4'd8;
    localparam logic [3:0] S_Q_DATA  = 4'd9;

    // Degree update steps of one edge
    localparam logic [1:0] STEP_IN_DST  = 2'd0;
    localparam logic [1:0] STEP_OUT_SRC = 2'd1;
    localparam logic [1:0] STEP_TOT_SRC = 2'd2;
    localparam logic [1:0] STEP_TOT_DST = 2'd3;

    localparam logic [DW-1:0] DEG_MAX = DW'(MAX_DEGREE);

    // Memories
    logic [DW-1:0]    deg_mem  [0:DEG_DEPTH-1];
    logic [CNT_W-1:0] hist_mem [0:HIST_DEPTH-1];

    // Control and data registers
    logic [3:0]        r_state, n_state;
    logic [CW+1:0]     r_clr;
    logic [1:0]        r_step, n_step;
    logic [NODE_W-1:0] r_src, r_dst;
    logic [DW-1:0]     r_deg;
    logic [HAW-1:0]    r_hidx;
    logic [HAW+1:0]    r_qaddr;
    logic              r_qok;
    logic              r_sat, n_sat;
    logic [DW-1:0]     r_dq;
    logic [CNT_W-1:0]  r_hq;
    logic              r_out_valid;
    t_res              r_out;

    // Memory ports
    logic                  deg_we;
    logic [AW+1:0]         deg_waddr, deg_raddr;
    logic [DW-1:0]         deg_wdata;
    logic                  hist_we;
    logic [HAW+1:0]        hist_waddr, hist_raddr;
    logic [CNT_W-1:0]      hist_wdata;

    // Shared +/-1 unit
    logic [UW-1:0] add_a, add_y;
    logic          add_dec;

    // Decode of the current step and the incoming request
    logic [KIND_W-1:0] step_kind;
    logic [NODE_W-1:0] step_node;
    logic [31:0]       node_w, src_w, dst_w, qdeg_w, qidx_w;
    logic [AW-1:0]     node_idx;
    logic [HAW-1:0]    q_idx;
    logic              q_ok, edge_ok, in_take, step_last, out_load, clr_done;
    logic [KIND_W-1:0] q_kind;
    logic [1:0]        clr_kind;

    assign step_kind = (r_step == STEP_IN_DST)  ? KIND_IN :
                       (r_step == STEP_OUT_SRC) ? KIND_OUT : KIND_TOT;
    assign step_node = (r_step == STEP_OUT_SRC || r_step == STEP_TOT_SRC) ? r_src : r_dst;
    assign node_w    = 32'(step_node);
    assign node_idx  = node_w[AW-1:0];
    assign step_last = (r_step == STEP_TOT_DST);

    assign src_w   = 32'(i_in.src_node);
    assign dst_w   = 32'(i_in.dst_node);
    assign edge_ok = (src_w < 32'(NODES)) && (dst_w < 32'(NODES));
    assign qdeg_w  = 32'(i_in.query_degree);
    assign qidx_w  = qdeg_w - 32'd1;
    assign q_idx   = qidx_w[HAW-1:0];
    assign q_ok    = (qdeg_w >= 32'd1) && (qdeg_w <= 32'(MAX_DEGREE)) &&
                     (i_in.query_kind == KIND_IN || i_in.query_kind == KIND_OUT ||
                      i_in.query_kind == KIND_TOT);
    assign q_kind  = q_ok ? i_in.query_kind : KIND_IN;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_Q_DATA) && (!r_out_valid || !i_out_stall);
    assign clr_kind = r_clr[CW+1:CW];
    assign clr_done = (r_clr == {KIND_TOT, {CW{1'b1}}});

    // Select the operand and direction of the shared unit
    always_comb begin
        add_a   = '0;
        add_dec = 1'b0;
        case (r_state)
            S_DEG_CHK: begin
                add_a = UW'(r_dq);
            end
            S_DEC_RD: begin
                add_a   = UW'(r_deg);
                add_dec = 1'b1;
            end
            S_DEC_WR: begin
                add_a   = UW'(r_hq);
                add_dec = 1'b1;
            end
            S_INC_WR: begin
                add_a = UW'(r_hq);
            end
            default: begin
                add_a = '0;
            end
        endcase
        add_y = add_dec ? (add_a - UW'(1)) : (add_a + UW'(1));
    end

    // Drive memory addresses and write enables
    always_comb begin
        deg_we     = 1'b0;
        deg_waddr  = {step_kind, node_idx};
        deg_wdata  = add_y[DW-1:0];
        deg_raddr  = {step_kind, node_idx};
        hist_we    = 1'b0;
        hist_waddr = {step_kind, r_hidx};
        hist_wdata = add_y[CNT_W-1:0];
        hist_raddr = r_qaddr;
        case (r_state)
            S_CLEAR: begin
                deg_we     = 1'b1;
                deg_waddr  = {clr_kind, r_clr[AW-1:0]};
                deg_wdata  = '0;
                hist_we    = 1'b1;
                hist_waddr = {clr_kind, r_clr[HAW-1:0]};
                hist_wdata = '0;
            end
            S_DEG_CHK: begin
                deg_we = (r_dq < DEG_MAX);
            end
            S_DEC_RD: begin
                hist_raddr = {step_kind, add_y[HAW-1:0]};
            end
            S_DEC_WR: begin
                hist_we = 1'b1;
            end
            S_INC_RD: begin
                hist_raddr = {step_kind, r_deg[HAW-1:0]};
            end
            S_INC_WR: begin
                hist_we    = 1'b1;
                hist_waddr = {step_kind, r_deg[HAW-1:0]};
            end
            default: begin
                deg_we = 1'b0;
            end
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        r_dq <= deg_mem[deg_raddr];
        r_hq <= hist_mem[hist_raddr];
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sat   = r_sat;
        case (r_state)
            S_CLEAR: begin
                if (clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    if (i_in.command == CMD_QUERY) begin
                        n_state = S_Q_WAIT;
                    end else if (edge_ok) begin
                        n_state = S_DEG_RD;
                        n_step  = STEP_IN_DST;
                    end
                end
            end
            S_DEG_RD: begin
                n_state = S_DEG_CHK;
            end
            S_DEG_CHK: begin
                if (r_dq >= DEG_MAX) begin
                    n_sat = 1'b1;
                    if (step_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DEG_RD;
                        n_step  = r_step + 2'd1;
                    end
                end else begin
                    if (add_y[DW-1:0] == DEG_MAX) begin
                        n_sat = 1'b1;
                    end
                    n_state = (r_dq != '0) ? S_DEC_RD : S_INC_RD;
                end
            end
            S_DEC_RD: begin
                n_state = S_DEC_WR;
            end
            S_DEC_WR: begin
                n_state = S_INC_RD;
            end
            S_INC_RD: begin
                n_state = S_INC_WR;
            end
            S_INC_WR: begin
                if (step_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DEG_RD;
                    n_step  = r_step + 2'd1;
                end
            end
            S_Q_WAIT: begin
                n_state = S_Q_DATA;
            end
            S_Q_DATA: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_step      <= STEP_IN_DST;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sat   <= n_sat;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + (CW+2)'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold request fields and intermediate values
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_src   <= i_in.src_node;
            r_dst   <= i_in.dst_node;
            r_qok   <= q_ok;
            r_qaddr <= {q_kind, q_idx};
        end
        if (r_state == S_DEG_CHK) begin
            r_deg <= r_dq;
        end
        if (r_state == S_DEC_RD) begin
            r_hidx <= add_y[HAW-1:0];
        end
        if (out_load) begin
            r_out.node_count <= r_qok ? r_hq : '0;
            r_out.saturated  <= r_sat;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    a_sat_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |=> r_sat)
        else $error("saturation flag dropped");

    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_Q_DATA)
        else $error("result without a query");

    a_deg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deg_we |-> deg_wdata <= DEG_MAX)
        else $error("degree written above maximum");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !in_take)
        else $error("request taken during clearing pass");

    a_hist_dec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC_RD) |-> r_deg != '0)
        else $error("bucket decrement for degree zero");

endmodule

/* dv/gdh_checker.sv */
// Scoreboard for graph_degree_histogram: mirrors the degree stores and the three
// degree histograms, predicts each query answer and compares accepted results.
// Depends on gdh_pkg.
`timescale 1ns / 1ps

module gdh_checker
    import gdh_pkg::*;
#(
    parameter int NODES      = 4096,
    parameter int MAX_DEGREE = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_req i_in,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_res i_out,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int DEG_W = $clog2(MAX_DEGREE + 1);

    // Mirror of the per-node degrees and the degree histograms
    logic [DEG_W-1:0] in_deg  [NODES];
    logic [DEG_W-1:0] out_deg [NODES];
    logic [DEG_W-1:0] tot_deg [NODES];
    logic [CNT_W-1:0] in_hist  [MAX_DEGREE];
    logic [CNT_W-1:0] out_hist [MAX_DEGREE];
    logic [CNT_W-1:0] tot_hist [MAX_DEGREE];
    logic             sat_seen;

    t_res expected_answers[$];
    int   fail_count;
    int   pending_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Raise one degree by one step and move the node to its new bucket.
    // A degree already at the ceiling stays put but marks saturation again.
    task automatic raise_degree(input logic [KIND_W-1:0] kind, input int node);
        int d;
        case (kind)
            KIND_IN:  d = int'(in_deg[node]);
            KIND_OUT: d = int'(out_deg[node]);
            default:  d = int'(tot_deg[node]);
        endcase
        if (d >= MAX_DEGREE) begin
            sat_seen = 1'b1;
            return;
        end
        case (kind)
            KIND_IN: begin
                if (d > 0) in_hist[d-1] = in_hist[d-1] - CNT_W'(1);
                in_hist[d]   = in_hist[d] + CNT_W'(1);
                in_deg[node] = DEG_W'(d + 1);
            end
            KIND_OUT: begin
                if (d > 0) out_hist[d-1] = out_hist[d-1] - CNT_W'(1);
                out_hist[d]   = out_hist[d] + CNT_W'(1);
                out_deg[node] = DEG_W'(d + 1);
            end
            default: begin
                if (d > 0) tot_hist[d-1] = tot_hist[d-1] - CNT_W'(1);
                tot_hist[d]   = tot_hist[d] + CNT_W'(1);
                tot_deg[node] = DEG_W'(d + 1);
            end
        endcase
        if (d + 1 == MAX_DEGREE) sat_seen = 1'b1;
    endtask

    // Apply one directed edge; a self-loop raises the total degree twice
    task automatic add_edge(input int src, input int dst);
        if (src >= NODES || dst >= NODES) return;
        raise_degree(KIND_IN, dst);
        raise_degree(KIND_OUT, src);
        raise_degree(KIND_TOT, src);
        raise_degree(KIND_TOT, dst);
    endtask

    function automatic t_res histogram_answer(input t_req req);
        t_res ans;
        int   deg;
        deg            = int'(req.query_degree);
        ans.node_count = '0;
        ans.saturated  = sat_seen;
        if (deg >= 1 && deg <= MAX_DEGREE) begin
            case (req.query_kind)
                KIND_IN:  ans.node_count = in_hist[deg-1];
                KIND_OUT: ans.node_count = out_hist[deg-1];
                KIND_TOT: ans.node_count = tot_hist[deg-1];
                default:  ans.node_count = '0;
            endcase
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        int   i;
        if (!i_rst_n) begin
            // Clear the mirror along with the block
            for (i = 0; i < NODES; i++) begin
                in_deg[i]  = '0;
                out_deg[i] = '0;
                tot_deg[i] = '0;
            end
            for (i = 0; i < MAX_DEGREE; i++) begin
                in_hist[i]  = '0;
                out_hist[i] = '0;
                tot_hist[i] = '0;
            end
            sat_seen = 1'b0;
            expected_answers.delete();
        end else begin
            // Compare a delivered result with the oldest outstanding answer
            if (i_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    report_failure($sformatf("result with no query outstanding: count %0d sat %0b",
                                             i_out.node_count, i_out.saturated));
                end else begin
                    want = expected_answers.pop_front();
                    if (i_out.node_count !== want.node_count) begin
                        report_failure($sformatf("node_count: expected %0d, got %0d",
                                                 want.node_count, i_out.node_count));
                    end
                    if (i_out.saturated !== want.saturated) begin
                        report_failure($sformatf("saturated: expected %0b, got %0b",
                                                 want.saturated, i_out.saturated));
                    end
                end
            end
            // Track each accepted request in order
            if (i_in_valid && !i_in_stall) begin
                if (i_in.command == CMD_QUERY) begin
                    expected_answers.push_back(histogram_answer(i_in));
                end else begin
                    add_edge(int'(i_in.src_node), int'(i_in.dst_node));
                end
            end
        end
        pending_count = expected_answers.size();
    end

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

endmodule

/* dv/tb.sv */
// Top of the graph_degree_histogram testbench: clock, reset, request and stall
// stimulus, and the final verdict. Depends on gdh_pkg, graph_degree_histogram and
// gdh_checker.
`timescale 1ns / 1ps

module tb;
    import gdh_pkg::*;

    localparam int NODES        = 4096;
    localparam int MAX_DEGREE   = 1024;
    localparam int RAND_ITEMS   = 1600;
    localparam int QUIET_TAIL   = 200;
    localparam int DRAIN_CYCLES = 40;
    // Histogram kind that names no histogram
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_req in_req   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_res out_res;
    int   fail_count;
    int   pending;
    bit   idle_on   = 1'b1;

    logic [NODE_W-1:0] hot_node;

    always #5 i_clk = ~i_clk;

    graph_degree_histogram #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    gdh_checker #(
        .NODES      (NODES),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Edge request; the query fields carry noise
    function automatic t_req edge_request(input logic [NODE_W-1:0] src,
                                          input logic [NODE_W-1:0] dst);
        t_req req;
        req.command      = CMD_ADD;
        req.src_node     = src;
        req.dst_node     = dst;
        req.query_kind   = KIND_W'($urandom);
        req.query_degree = QDEG_W'($urandom);
        return req;
    endfunction

    // Query request; the node fields carry noise
    function automatic t_req query_request(input logic [KIND_W-1:0] kind,
                                           input logic [QDEG_W-1:0] deg);
        t_req req;
        req.command      = CMD_QUERY;
        req.src_node     = NODE_W'($urandom);
        req.dst_node     = NODE_W'($urandom);
        req.query_kind   = kind;
        req.query_degree = deg;
        return req;
    endfunction

    // Favor small degrees where most nodes sit, with edges and the hot range mixed in
    function automatic logic [QDEG_W-1:0] pick_degree();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return QDEG_W'($urandom_range(1, 6));
            5: begin
                case ($urandom_range(0, 5))
                    0:       return QDEG_W'(0);
                    1:       return QDEG_W'(1);
                    2:       return QDEG_W'(MAX_DEGREE - 1);
                    3:       return QDEG_W'(MAX_DEGREE);
                    4:       return QDEG_W'(MAX_DEGREE + 1);
                    default: return '1;
                endcase
            end
            6, 7:    return QDEG_W'($urandom_range(1, MAX_DEGREE));
            8:       return QDEG_W'($urandom);
            default: return QDEG_W'($urandom_range(MAX_DEGREE - 24, MAX_DEGREE));
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        if ($urandom_range(0, 9) == 0) return KIND_NONE;
        return KIND_W'($urandom_range(0, 2));
    endfunction

    // Present one request, with an optional idle burst first, and hold it until taken
    task automatic send_request(input t_req req);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    // Stall the result side in random bursts while idling is on
    initial begin : result_stall
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int n;
        int roll;
        logic [NODE_W-1:0] src;

        hot_node = NODE_W'($urandom);
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme nodes, a self-loop, every kind, degree bounds
        send_request(t_req'(0));
        send_request(edge_request('0, '0));
        send_request(edge_request('1, '1));
        send_request(edge_request('0, '1));
        send_request(edge_request('1, '0));
        send_request(edge_request(12'd1, 12'd2));
        send_request(edge_request(12'd1, 12'd2));
        send_request(query_request(KIND_IN, 11'd1));
        send_request(query_request(KIND_OUT, 11'd1));
        send_request(query_request(KIND_TOT, 11'd1));
        send_request(query_request(KIND_NONE, 11'd1));
        send_request(query_request(KIND_IN, 11'd2));
        send_request(query_request(KIND_OUT, 11'd2));
        send_request(query_request(KIND_TOT, 11'd2));
        send_request(query_request(KIND_TOT, 11'd4));
        send_request(query_request(KIND_TOT, 11'd6));
        send_request(query_request(KIND_IN, 11'd0));
        send_request(query_request(KIND_IN, QDEG_W'(MAX_DEGREE)));
        send_request(query_request(KIND_OUT, QDEG_W'(MAX_DEGREE + 1)));
        send_request(query_request(KIND_TOT, '1));
        send_request(t_req'('1));

        // Random: edges pile onto one hot node so its degrees run into the ceiling
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) begin
                idle_on = (n < RAND_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                send_request(query_request(pick_kind(), pick_degree()));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    if ($urandom_range(0, 7) == 0) src = NODE_W'($urandom);
                    else src = NODE_W'($urandom_range(0, 31));
                    send_request(edge_request(src, hot_node));
                end else if (roll < 85) begin
                    send_request(edge_request(hot_node, hot_node));
                end else begin
                    send_request(edge_request(NODE_W'($urandom), NODE_W'($urandom)));
                end
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding answers, then let the last edge settle
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
